@@ hdl/imu_six_axis_kalman_lowpass_top_assert.svh @@
// Assertion macros used by the top-level RTL file of the IMU filter.
`ifndef IMU_SIX_AXIS_KALMAN_LOWPASS_TOP_ASSERT_SVH
`define IMU_SIX_AXIS_KALMAN_LOWPASS_TOP_ASSERT_SVH
`ifndef SYNTH
`define IKL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("imu filter check failed");
`define IKL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("imu filter check failed during reset");
`else
`define IKL_ASSERT(lbl, prop)
`define IKL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hdl/ikl_pkg.sv @@
package ikl_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] accel_x_si;
        logic signed [31:0] accel_y_si;
        logic signed [31:0] accel_z_si;
        logic signed [31:0] rate_x_si;
        logic signed [31:0] rate_y_si;
        logic signed [31:0] rate_z_si;
    } result_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 33;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_OFFSETS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSETS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_ALPHA = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_GAIN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_NOISE = 3'd6;

    localparam logic [16:0] ALPHA_ONE        = 17'd65536;
    localparam logic [31:0] ACCEL_GAIN_RESET = 32'd2570740;
    localparam logic [31:0] GYRO_GAIN_RESET  = 32'd572220;
    localparam logic [31:0] PROC_NOISE_RESET = 32'd300648;
    localparam logic [31:0] MEAS_NOISE_RESET = 32'd1288490;
    localparam logic [31:0] COV_RESET        = 32'd85899346;
    localparam logic [32:0] KG_ONE           = 33'h1_0000_0000;

    function automatic logic [31:0] magnitude(input logic signed [32:0] v);
        logic signed [32:0] n;
        begin
            n = -v;
            magnitude = v[32] ? n[31:0] : v[31:0];
        end
    endfunction

endpackage

@@ hdl/imu_six_axis_kalman_lowpass_top.sv @@
// Six-axis IMU filter: per axis it removes the offset, runs a scalar Kalman update and a
// first-order low-pass, and scales to m/s^2 or rad/s as saturated Q16.16. For each item a
// restoring divider forms the Kalman gain (it is skipped when the Kalman divisor is zero),
// the states S_COV and S_COVW update the covariance, then one shared 32x33 multiplier runs
// three multiplies per axis. A new item is taken only while the sequencer is idle, in the
// cycle after the result is written; a finished result waits in an output register, so the
// next item can be accepted before it is taken.
`include "imu_six_axis_kalman_lowpass_top_assert.svh"
module imu_six_axis_kalman_lowpass_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  ikl_pkg::sample_t                    sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ikl_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [ikl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ikl_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ikl_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DINIT = 4'd1;
    localparam logic [3:0] S_DIV = 4'd2;
    localparam logic [3:0] S_COV = 4'd3;
    localparam logic [3:0] S_COVW = 4'd4;
    localparam logic [3:0] S_KMUL = 4'd5;
    localparam logic [3:0] S_KADD = 4'd6;
    localparam logic [3:0] S_LMUL = 4'd7;
    localparam logic [3:0] S_LADD = 4'd8;
    localparam logic [3:0] S_OMUL = 4'd9;
    localparam logic [3:0] S_OSAT = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [47:0] acc_off_reg;
    logic [47:0] gyr_off_reg;
    logic [16:0] alpha_reg;
    logic [31:0] acc_gain_reg;
    logic [31:0] gyr_gain_reg;
    logic [31:0] qn_reg;
    logic [31:0] rn_reg;

    logic [3:0]  state_reg, state_next;
    logic [31:0] cov_reg;
    logic [31:0] now_p_reg;
    logic [32:0] denom_reg;
    logic [33:0] rem_reg;
    logic [32:0] kg_reg;
    logic [4:0]  cnt_reg;
    logic [2:0]  ch_reg;
    logic        neg_reg;
    logic signed [31:0] kal_reg [6];
    logic signed [31:0] lp_reg [6];
    logic signed [31:0] res_reg [6];
    sample_t     smp_reg;
    result_t     result_reg;
    logic        result_valid_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    logic [32:0] sum_p;
    logic [31:0] now_p;
    logic [32:0] denom;
    logic [33:0] rem_sh;
    logic signed [15:0] raw;
    logic signed [15:0] offs;
    logic signed [16:0] mdiff;
    logic signed [30:0] meas;
    logic signed [32:0] kdiff;
    logic signed [32:0] ldiff;
    logic [16:0] alpha;
    logic [31:0] gain;
    logic [32:0] kstep;
    logic [32:0] lstep;
    logic [35:0] ostep;
    logic signed [31:0] kal_new;
    logic signed [31:0] lp_new;
    logic signed [31:0] sat;
    logic        out_free;

    ikl_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    assign sum_p = {1'b0, cov_reg} + {1'b0, qn_reg};
    assign now_p = sum_p[32] ? 32'hFFFF_FFFF : sum_p[31:0];
    assign denom = {1'b0, now_p_reg} + {1'b0, rn_reg};
    assign rem_sh = {rem_reg[32:0], 1'b0};
    assign alpha = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign gain = (ch_reg < 3'd3) ? acc_gain_reg : gyr_gain_reg;
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        unique case (ch_reg)
            3'd0: begin raw = smp_reg.accel_x; offs = acc_off_reg[15:0]; end
            3'd1: begin raw = smp_reg.accel_y; offs = acc_off_reg[31:16]; end
            3'd2: begin raw = smp_reg.accel_z; offs = acc_off_reg[47:32]; end
            3'd3: begin raw = smp_reg.rate_x; offs = gyr_off_reg[15:0]; end
            3'd4: begin raw = smp_reg.rate_y; offs = gyr_off_reg[31:16]; end
            default: begin raw = smp_reg.rate_z; offs = gyr_off_reg[47:32]; end
        endcase
    end

    assign mdiff = {raw[15], raw} - {offs[15], offs};
    assign meas = {mdiff, 14'd0};
    assign kdiff = 33'(meas) - 33'(kal_reg[ch_reg]);
    assign ldiff = 33'(kal_reg[ch_reg]) - 33'(lp_reg[ch_reg]);

    assign kstep = 33'((prod + MUL_P_W'(64'h8000_0000)) >> 32);
    assign lstep = 33'((prod + MUL_P_W'(64'h8000)) >> 16);
    assign ostep = 36'((prod + MUL_P_W'(64'h2000_0000)) >> 30);
    assign kal_new = neg_reg ? kal_reg[ch_reg] - kstep[31:0] : kal_reg[ch_reg] + kstep[31:0];
    assign lp_new = neg_reg ? lp_reg[ch_reg] - lstep[31:0] : lp_reg[ch_reg] + lstep[31:0];

    always_comb
    begin
        if (neg_reg)
        begin
            sat = (ostep > 36'h8000_0000) ? 32'sh8000_0000 : -$signed(ostep[31:0]);
        end
        else
        begin
            sat = (ostep > 36'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(ostep[31:0]);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_COV: begin mul_a = now_p_reg; mul_b = KG_ONE - kg_reg; end
            S_KMUL: begin mul_a = magnitude(kdiff); mul_b = kg_reg; end
            S_LMUL: begin mul_a = magnitude(ldiff); mul_b = {16'd0, alpha}; end
            S_OMUL: begin mul_a = magnitude(33'(lp_reg[ch_reg])); mul_b = {1'b0, gain}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (sample_valid) state_next = S_DINIT;
            S_DINIT: state_next = (denom == 33'd0) ? S_COV : S_DIV;
            S_DIV:   if (cnt_reg == 5'd0) state_next = S_COV;
            S_COV:   state_next = S_COVW;
            S_COVW:  state_next = S_KMUL;
            S_KMUL:  state_next = S_KADD;
            S_KADD:  state_next = S_LMUL;
            S_LMUL:  state_next = S_LADD;
            S_LADD:  state_next = S_OMUL;
            S_OMUL:  state_next = S_OSAT;
            S_OSAT:  state_next = (ch_reg == 3'd5) ? S_DONE : S_KMUL;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign sample_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            result_valid_reg <= 1'b0;
            acc_off_reg <= '0;
            gyr_off_reg <= '0;
            alpha_reg <= ALPHA_ONE;
            acc_gain_reg <= ACCEL_GAIN_RESET;
            gyr_gain_reg <= GYRO_GAIN_RESET;
            qn_reg <= PROC_NOISE_RESET;
            rn_reg <= MEAS_NOISE_RESET;
            cov_reg <= COV_RESET;
            ch_reg <= '0;
            cnt_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                kal_reg[i] <= '0;
                lp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ACCEL_OFFSETS: acc_off_reg <= cfg_data;
                    REG_GYRO_OFFSETS:  gyr_off_reg <= cfg_data;
                    REG_LOWPASS_ALPHA: alpha_reg <= cfg_data[16:0];
                    REG_ACCEL_GAIN:    acc_gain_reg <= cfg_data[31:0];
                    REG_GYRO_GAIN:     gyr_gain_reg <= cfg_data[31:0];
                    REG_PROCESS_NOISE: qn_reg <= cfg_data[31:0];
                    REG_MEASURE_NOISE: rn_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_DINIT:
                begin
                    cnt_reg <= 5'd31;
                    ch_reg <= '0;
                end
                S_DIV:   cnt_reg <= cnt_reg - 5'd1;
                S_COVW:  cov_reg <= prod[63:32];
                S_KADD:  kal_reg[ch_reg] <= kal_new;
                S_LADD:  lp_reg[ch_reg] <= lp_new;
                S_OSAT:  if (ch_reg != 3'd5) ch_reg <= ch_reg + 3'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                smp_reg <= sample;
                now_p_reg <= now_p;
            end
            S_DINIT:
            begin
                denom_reg <= denom;
                if (denom == 33'd0)
                begin
                    kg_reg <= KG_ONE;
                end
                else if ({1'b0, now_p_reg} >= denom)
                begin
                    kg_reg <= KG_ONE;
                    rem_reg <= 34'({1'b0, now_p_reg} - denom);
                end
                else
                begin
                    kg_reg <= '0;
                    rem_reg <= {2'b0, now_p_reg};
                end
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, denom_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, denom_reg};
                    kg_reg[cnt_reg] <= 1'b1;
                end
                else
                begin
                    rem_reg <= rem_sh;
                end
            end
            S_KMUL:  neg_reg <= kdiff[32];
            S_LMUL:  neg_reg <= ldiff[32];
            S_OMUL:  neg_reg <= lp_reg[ch_reg][31];
            S_OSAT:  res_reg[ch_reg] <= sat;
            S_DONE:
            begin
                if (out_free)
                begin
                    result_reg <= '{res_reg[0], res_reg[1], res_reg[2],
                                    res_reg[3], res_reg[4], res_reg[5]};
                end
            end
            default: ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    `IKL_ASSERT(a_div_rem_below, (state_reg == S_DIV) |-> (rem_reg < {1'b0, denom_reg}))
    `IKL_ASSERT(a_kg_bounded, (state_reg == S_COV) |-> (kg_reg <= KG_ONE))
    `IKL_ASSERT(a_done_delivers, (state_reg == S_DONE && out_free) |=> result_valid_reg)
    `IKL_ASSERT_ALWAYS(a_ch_range, ch_reg <= 3'd5)

endmodule

@@ hdl/ikl_mul.sv @@
module ikl_mul (
    input  logic                        clk,
    input  logic [ikl_pkg::MUL_A_W-1:0] a,
    input  logic [ikl_pkg::MUL_B_W-1:0] b,
    output logic [ikl_pkg::MUL_P_W-1:0] product
);
    import ikl_pkg::*;

    logic [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign product = product_reg;

endmodule
